>>> rtl/obm_pkg.sv
// Shared types and constants for the overlapping box merge unit.
// Holds the box geometry, request payload structs and coordinate width.
// No dependencies.
`default_nettype none

package obm_pkg;

	localparam int COORD_W = 16;

	// Geometry of one stored box
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] w;
		logic signed [COORD_W-1:0] h;
	} geom_t;

	// Incoming box request
	typedef struct packed {
		logic signed [COORD_W-1:0] box_x;
		logic signed [COORD_W-1:0] box_y;
		logic signed [COORD_W-1:0] box_w;
		logic signed [COORD_W-1:0] box_h;
		logic                      final_box;
	} box_req_t;

	// Outgoing merged box request
	typedef struct packed {
		logic signed [COORD_W-1:0] merged_x;
		logic signed [COORD_W-1:0] merged_y;
		logic signed [COORD_W-1:0] merged_w;
		logic signed [COORD_W-1:0] merged_h;
		logic                      last_group;
	} merged_req_t;

endpackage

`default_nettype wire

>>> rtl/obm_box_mem.sv
// Box store: one write port, one read port with registered read data.
// Depends on obm_pkg for the geometry type.
`default_nettype none

module obm_box_mem
	import obm_pkg::*;
#(
	parameter int DEPTH = 32,
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire geom_t            wr_data,
	input  wire logic [IDX_W-1:0] rd_addr,
	output geom_t                 rd_data
);

	geom_t mem_q [DEPTH];

	// Write the incoming box
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Register the read data
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

>>> rtl/obm_overlap.sv
// Strict overlap test between the group leader and one candidate box.
// Depends on obm_pkg for the geometry type.
`default_nettype none

module obm_overlap
	import obm_pkg::*;
(
	input  wire geom_t lead,
	input  wire geom_t cand,
	output logic       hit
);

	logic signed [COORD_W:0] lx, ly, lr, lb;
	logic signed [COORD_W:0] cx, cy, cr, cb;

	// Form edges at one extra bit so the sums never wrap
	always_comb begin
		lx = {lead.x[COORD_W-1], lead.x};
		ly = {lead.y[COORD_W-1], lead.y};
		lr = {lead.x[COORD_W-1], lead.x} + {lead.w[COORD_W-1], lead.w};
		lb = {lead.y[COORD_W-1], lead.y} + {lead.h[COORD_W-1], lead.h};
		cx = {cand.x[COORD_W-1], cand.x};
		cy = {cand.y[COORD_W-1], cand.y};
		cr = {cand.x[COORD_W-1], cand.x} + {cand.w[COORD_W-1], cand.w};
		cb = {cand.y[COORD_W-1], cand.y} + {cand.h[COORD_W-1], cand.h};
		hit = (lx < cr) && (ly < cb) && (lr > cx) && (lb > cy);
	end

endmodule

`default_nettype wire

>>> rtl/obm_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Divides a wide group sum by the member count. Depends on obm_pkg.
`default_nettype none

module obm_divider
	import obm_pkg::*;
#(
	parameter int CNT_W = 6,
	localparam int SUM_W = COORD_W + CNT_W
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [SUM_W-1:0] dividend,
	input  wire logic [CNT_W-1:0] divisor,
	output logic                  done,
	output logic [COORD_W-1:0]    quotient
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W:0]    rem_q;
	logic [STEP_W-1:0] step_q;
	logic              neg_q;
	logic              done_q;
	logic [CNT_W:0]    trial;
	logic              ge;
	logic [CNT_W:0]    rem_nxt;
	logic [SUM_W-1:0]  mag;
	logic [COORD_W-1:0] q_lo;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial   = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
		ge      = trial >= {1'b0, divisor};
		rem_nxt = ge ? (trial - {1'b0, divisor}) : trial;
		mag     = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
		q_lo    = quo_q[COORD_W-1:0];
	end

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= STEP_W'(SUM_W);
			end else if (step_q != '0) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Hold the working magnitude and remainder
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			neg_q <= dividend[SUM_W-1];
		end else if (step_q != '0) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~q_lo + 1'b1) : q_lo;

endmodule

`default_nettype wire

>>> rtl/overlapping_box_merge_unit.sv
// Overlapping box merge unit.
// Box requests arrive on box/box_valid/box_stall, one box each. A box with
// final_box set closes the set and starts merging; boxes beyond MAX_BOXES are
// dropped. Loading takes one box per cycle. While merging, box_stall is high.
// Merging walks the stored boxes in order: each unused box leads a group and
// every later unused box that strictly overlaps the leader joins it. Each
// group reads the leader, then visits every later stored box (memory read,
// then overlap test and accumulate), then divides the four sums in turn in
// the shared bit-serial divider (SUM_W = 16 + bits of the box count, 22 at
// 32 boxes). Used boxes are skipped while scanning for the next leader, and
// the result is held in the output register.
// The averaged box is held in an output register on merged/merged_valid
// until merged_stall is low; the sequencer waits there, so a stalled
// receiver only pauses merging. last_group marks the final group, after
// which the unit returns to loading.
// Reset clears the box count, used marks, sequencer and output valid; the
// box store itself needs no clearing since only freshly written entries
// are read.
// Depends on obm_pkg, obm_box_mem, obm_overlap and obm_divider.
`default_nettype none

module overlapping_box_merge_unit
	import obm_pkg::*;
#(
	parameter int MAX_BOXES = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        box_valid,
	output logic             box_stall,
	input  wire box_req_t    box,
	output logic             merged_valid,
	input  wire logic        merged_stall,
	output merged_req_t      merged
);

	localparam int IDX_W = $clog2(MAX_BOXES);
	localparam int CNT_W = $clog2(MAX_BOXES + 1);
	localparam int SUM_W = COORD_W + CNT_W;
	localparam int EXT_W = SUM_W - COORD_W;

	localparam logic [1:0] SEL_X = 2'd0;
	localparam logic [1:0] SEL_Y = 2'd1;
	localparam logic [1:0] SEL_W = 2'd2;
	localparam logic [1:0] SEL_H = 2'd3;

	typedef enum logic [6:0] {
		S_LOAD = 7'b0000001,
		S_SCAN = 7'b0000010,
		S_LEAD = 7'b0000100,
		S_RD   = 7'b0001000,
		S_CMP  = 7'b0010000,
		S_DIV  = 7'b0100000,
		S_EMIT = 7'b1000000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [MAX_BOXES-1:0] used_q;
	logic [IDX_W-1:0]   i_q;
	logic [CNT_W-1:0]   j_q;
	logic [CNT_W-1:0]   j_nxt;
	logic [CNT_W-1:0]   i_nxt;
	logic [CNT_W-1:0]   member_q;
	logic [1:0]         sel_q;
	logic               div_pend_q;
	logic               merged_valid_q;
	merged_req_t        merged_q;
	geom_t              lead_q;
	logic [SUM_W-1:0]   sum_q [4];

	logic               wr_en;
	geom_t              wr_data;
	logic [IDX_W-1:0]   rd_addr;
	geom_t              rd_data;
	logic               hit;
	logic               div_start;
	logic               div_done;
	logic [COORD_W-1:0] div_q;
	logic [MAX_BOXES-1:0] done_mask;
	logic               all_used;

	// Store incoming boxes while there is room
	always_comb begin
		wr_en   = (state_q == S_LOAD) && box_valid && (count_q < CNT_W'(MAX_BOXES));
		wr_data = '{x: box.box_x, y: box.box_y, w: box.box_w, h: box.box_h};
		rd_addr = (state_q == S_SCAN) ? i_q : j_q[IDX_W-1:0];
		j_nxt   = j_q + 1'b1;
		i_nxt   = CNT_W'(i_q) + 1'b1;
	end

	obm_box_mem #(.DEPTH(MAX_BOXES)) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	obm_overlap u_overlap (
		.lead (lead_q),
		.cand (rd_data),
		.hit  (hit)
	);

	assign div_start = (state_q == S_DIV) && !div_pend_q;

	obm_divider #(.CNT_W(CNT_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q[sel_q]),
		.divisor  (member_q),
		.done     (div_done),
		.quotient (div_q)
	);

	// Detect whether every stored box has been taken into a group
	always_comb begin
		for (int k = 0; k < MAX_BOXES; k++) begin
			done_mask[k] = used_q[k] | (CNT_W'(k) >= count_q);
		end
		all_used = &done_mask;
	end

	// Sequence loading, grouping, dividing and emitting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_LOAD;
			count_q        <= '0;
			used_q         <= '0;
			i_q            <= '0;
			j_q            <= '0;
			member_q       <= '0;
			sel_q          <= SEL_X;
			div_pend_q     <= 1'b0;
			merged_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (box_valid) begin
						if (count_q < CNT_W'(MAX_BOXES)) begin
							count_q <= count_q + 1'b1;
						end
						if (box.final_box) begin
							i_q     <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (used_q[i_q]) begin
						i_q <= i_q + 1'b1;
					end else begin
						state_q <= S_LEAD;
					end
				end
				S_LEAD: begin
					used_q[i_q] <= 1'b1;
					member_q    <= CNT_W'(1);
					j_q         <= i_nxt;
					sel_q       <= SEL_X;
					state_q     <= (i_nxt < count_q) ? S_RD : S_DIV;
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (!used_q[j_q[IDX_W-1:0]] && hit) begin
						used_q[j_q[IDX_W-1:0]] <= 1'b1;
						member_q <= member_q + 1'b1;
					end
					j_q     <= j_nxt;
					state_q <= (j_nxt < count_q) ? S_RD : S_DIV;
				end
				S_DIV: begin
					if (!div_pend_q) begin
						div_pend_q <= 1'b1;
					end else if (div_done) begin
						div_pend_q <= 1'b0;
						sel_q      <= sel_q + 1'b1;
						if (sel_q == SEL_H) begin
							merged_valid_q <= 1'b1;
							state_q        <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (!merged_stall) begin
						merged_valid_q <= 1'b0;
						if (merged_q.last_group) begin
							count_q <= '0;
							used_q  <= '0;
							state_q <= S_LOAD;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_SCAN;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Latch the leader and accumulate member sums
	always_ff @(posedge clk) begin
		if (state_q == S_LEAD) begin
			lead_q   <= rd_data;
			sum_q[0] <= {{EXT_W{rd_data.x[COORD_W-1]}}, rd_data.x};
			sum_q[1] <= {{EXT_W{rd_data.y[COORD_W-1]}}, rd_data.y};
			sum_q[2] <= {{EXT_W{rd_data.w[COORD_W-1]}}, rd_data.w};
			sum_q[3] <= {{EXT_W{rd_data.h[COORD_W-1]}}, rd_data.h};
		end else if ((state_q == S_CMP) && !used_q[j_q[IDX_W-1:0]] && hit) begin
			sum_q[0] <= sum_q[0] + {{EXT_W{rd_data.x[COORD_W-1]}}, rd_data.x};
			sum_q[1] <= sum_q[1] + {{EXT_W{rd_data.y[COORD_W-1]}}, rd_data.y};
			sum_q[2] <= sum_q[2] + {{EXT_W{rd_data.w[COORD_W-1]}}, rd_data.w};
			sum_q[3] <= sum_q[3] + {{EXT_W{rd_data.h[COORD_W-1]}}, rd_data.h};
		end
	end

	// Collect the averaged fields into the output register
	always_ff @(posedge clk) begin
		if ((state_q == S_DIV) && div_pend_q && div_done) begin
			case (sel_q)
				SEL_X: merged_q.merged_x <= div_q;
				SEL_Y: merged_q.merged_y <= div_q;
				SEL_W: merged_q.merged_w <= div_q;
				SEL_H: begin
					merged_q.merged_h   <= div_q;
					merged_q.last_group <= all_used;
				end
				default: merged_q.merged_x <= div_q;
			endcase
		end
	end

	assign box_stall    = (state_q != S_LOAD);
	assign merged_valid = merged_valid_q;
	assign merged       = merged_q;

endmodule

`default_nettype wire
